### src/phh_pkg.sv
// ----------------------------------------------------------------------------
// phh_pkg
// Shared constants, codes and types of the pulse height histogrammer.
// ----------------------------------------------------------------------------
package phh_pkg;

   // sizing
   localparam int CHANNELS    = 64;
   localparam int BINS        = 16384;
   localparam int GROUP_SIZE  = 16;
   localparam int COUNT_WIDTH = 32;

   localparam int BIN_DEPTH = CHANNELS * BINS;
   localparam int BIN_AW    = $clog2(BIN_DEPTH);
   localparam int CH_AW     = $clog2(CHANNELS);

   // hits and overflows of one channel share a ram word
   localparam int CHAN_W = 2 * COUNT_WIDTH;

   // field widths
   localparam int FUNC_W   = 3;
   localparam int GROUP_W  = 2;
   localparam int MASK_W   = 16;
   localparam int WORD_W   = 16;
   localparam int SEL_W    = 3;
   localparam int RCH_W    = 6;
   localparam int RBIN_W   = 14;
   localparam int STATUS_W = 2;
   localparam int VALUE_W  = 32;
   localparam int CFG_W    = 3;
   localparam int BIT_W    = $clog2(GROUP_SIZE);

   localparam int OVF_BIT = 15;

   localparam logic [CFG_W-1:0] ACTIVE_GROUPS_RESET = 3'd4;

   // item kinds
   localparam logic [FUNC_W-1:0] FUNC_EVENT_START  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_GROUP_HEADER = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_DATA_WORD    = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_READ         = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR        = 3'd4;

   // read selects
   localparam logic [SEL_W-1:0] SEL_TOTAL    = 3'd0;
   localparam logic [SEL_W-1:0] SEL_PILEUP   = 3'd1;
   localparam logic [SEL_W-1:0] SEL_ACCEPTED = 3'd2;
   localparam logic [SEL_W-1:0] SEL_HITS     = 3'd3;
   localparam logic [SEL_W-1:0] SEL_OVERFLOW = 3'd4;
   localparam logic [SEL_W-1:0] SEL_BIN      = 3'd5;

   // result status
   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_IGNORED    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_CHANNEL = 2'd2;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_UPDATE,
      ST_CLEAR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load_item;
      logic update;
      logic sweep;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic is_clear;
      logic rsp_free;
   } dp_status_type;

   function automatic count_type bump(input count_type c);
      return (c == '1) ? c : c + 1'b1;
   endfunction

endpackage

### src/phh_ram.sv
// ----------------------------------------------------------------------------
// phh_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module phh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/phh_ctrl.sv
// ----------------------------------------------------------------------------
// phh_ctrl
// Sequencer: accept, look up, update, optional clearing sweep, hand off.
// ----------------------------------------------------------------------------
module phh_ctrl
   import phh_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type dp_status,
   output cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (dp_status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = dp_status.is_clear ? ST_CLEAR : ST_DONE;
         end
         ST_CLEAR: begin
            if (dp_status.sweep_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (dp_status.rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd.load_item = 1'b0;
      cmd.update    = 1'b0;
      cmd.sweep     = 1'b0;
      cmd.load_rsp  = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.sweep = 1'b1;
         end
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         ST_EXEC: begin
            // ram read issued from the held item
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
         end
         ST_DONE: begin
            cmd.load_rsp = dp_status.rsp_free;
         end
         default: begin
            cmd.sweep = 1'b0;
         end
      endcase
   end

endmodule

### src/phh_datapath.sv
// ----------------------------------------------------------------------------
// phh_datapath
// Item registers, event state, event counters, counter rams and result beat.
// ----------------------------------------------------------------------------
module phh_datapath
   import phh_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output dp_status_type       dp_status,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [GROUP_W-1:0]  req_group_index,
   input  logic                req_pileup_flag,
   input  logic [MASK_W-1:0]   req_channel_mask,
   input  logic [WORD_W-1:0]   req_data_word,
   input  logic [SEL_W-1:0]    req_read_select,
   input  logic [RCH_W-1:0]    req_read_channel,
   input  logic [RBIN_W-1:0]   req_read_bin,
   input  logic                csr_valid,
   input  logic [CFG_W-1:0]    csr_active_groups,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [VALUE_W-1:0]  rsp_read_value,
   output logic [RCH_W-1:0]    rsp_channel_used
);

   // held item
   logic [FUNC_W-1:0]  func_ff;
   logic [GROUP_W-1:0] group_ff;
   logic               pile_ff;
   logic [MASK_W-1:0]  mask_item_ff;
   logic [WORD_W-1:0]  word_ff;
   logic [SEL_W-1:0]   sel_ff;
   logic [RCH_W-1:0]   rch_ff;
   logic [RBIN_W-1:0]  rbin_ff;

   // event state and counters
   logic [CFG_W-1:0]   active_groups_ff;
   logic               rejected_ff, rejected_in;
   logic [GROUP_W-1:0] cur_group_ff, cur_group_in;
   logic [MASK_W-1:0]  remaining_ff, remaining_in;
   count_type          total_ff, total_in;
   count_type          pileup_ff, pileup_in;
   count_type          accepted_ff, accepted_in;

   // finished result and result beat
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [VALUE_W-1:0]  res_value_ff, res_value_in;
   logic [RCH_W-1:0]    res_used_ff, res_used_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [VALUE_W-1:0]  rsp_value_ff;
   logic [RCH_W-1:0]    rsp_used_ff;

   // clearing sweep
   logic [BIN_AW-1:0] sweep_ff, sweep_in;
   logic              sweep_last;

   // lookup
   logic [BIT_W-1:0]  low_bit;
   logic [RCH_W-1:0]  data_ch;
   logic              data_ch_ok;
   logic [RBIN_W-1:0] word_bin;
   logic              word_bin_ok;
   logic              rch_ok;
   logic              rbin_ok;
   logic [RCH_W-1:0]  sel_ch;
   logic [RBIN_W-1:0] sel_bin;
   logic [BIN_AW-1:0] bin_addr_calc;

   // rams
   logic              chan_we, chan_we_upd;
   logic [CH_AW-1:0]  chan_addr;
   logic [CHAN_W-1:0] chan_wdata, chan_wdata_upd, chan_rdata;
   logic              bin_we, bin_we_upd;
   logic [BIN_AW-1:0] bin_addr;
   count_type         bin_wdata, bin_wdata_upd, bin_rdata;
   count_type         hits_rd, ovf_rd;

   assign hits_rd = chan_rdata[COUNT_WIDTH-1:0];
   assign ovf_rd  = chan_rdata[CHAN_W-1:COUNT_WIDTH];

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         func_ff      <= req_func;
         group_ff     <= req_group_index;
         pile_ff      <= req_pileup_flag;
         mask_item_ff <= req_channel_mask;
         word_ff      <= req_data_word;
         sel_ff       <= req_read_select;
         rch_ff       <= req_read_channel;
         rbin_ff      <= req_read_bin;
      end
   end

   // lowest pending channel of the group
   always_comb begin
      low_bit = '0;
      for (int i = MASK_W - 1; i >= 0; i--) begin
         if (remaining_ff[i]) low_bit = BIT_W'(i);
      end
   end

   assign data_ch     = RCH_W'(cur_group_ff) * RCH_W'(GROUP_SIZE) + RCH_W'(low_bit);
   assign data_ch_ok  = int'(data_ch) < CHANNELS;
   assign word_bin    = word_ff[RBIN_W-1:0];
   assign word_bin_ok = int'(word_bin) < BINS;
   assign rch_ok      = int'(rch_ff) < CHANNELS;
   assign rbin_ok     = int'(rbin_ff) < BINS;

   // address is stable from lookup to update, as state only moves at update
   assign sel_ch        = (func_ff == FUNC_READ) ? rch_ff : data_ch;
   assign sel_bin       = (func_ff == FUNC_READ) ? rbin_ff : word_bin;
   assign bin_addr_calc = BIN_AW'(sel_ch) * BIN_AW'(BINS) + BIN_AW'(sel_bin);

   assign sweep_last = sweep_ff == BIN_AW'(BIN_DEPTH - 1);

   always_comb begin
      sweep_in = sweep_ff;
      if (cmd.sweep) begin
         sweep_in = sweep_last ? '0 : sweep_ff + 1'b1;
      end
   end

   always_comb begin
      if (cmd.sweep) begin
         chan_addr  = sweep_ff[CH_AW-1:0];
         chan_we    = int'(sweep_ff) < CHANNELS;
         chan_wdata = '0;
         bin_addr   = sweep_ff;
         bin_we     = 1'b1;
         bin_wdata  = '0;
      end else begin
         chan_addr  = sel_ch[CH_AW-1:0];
         chan_we    = cmd.update && chan_we_upd;
         chan_wdata = chan_wdata_upd;
         bin_addr   = bin_addr_calc;
         bin_we     = cmd.update && bin_we_upd;
         bin_wdata  = bin_wdata_upd;
      end
   end

   // item effect
   always_comb begin
      rejected_in    = rejected_ff;
      cur_group_in   = cur_group_ff;
      remaining_in   = remaining_ff;
      total_in       = total_ff;
      pileup_in      = pileup_ff;
      accepted_in    = accepted_ff;
      res_status_in  = STATUS_OK;
      res_value_in   = '0;
      res_used_in    = '0;
      chan_we_upd    = 1'b0;
      chan_wdata_upd = chan_rdata;
      bin_we_upd     = 1'b0;
      bin_wdata_upd  = bump(bin_rdata);
      case (func_ff)
         FUNC_EVENT_START: begin
            total_in     = bump(total_ff);
            rejected_in  = 1'b0;
            cur_group_in = '0;
            remaining_in = '0;
         end
         FUNC_GROUP_HEADER: begin
            if (rejected_ff) begin
               res_status_in = STATUS_IGNORED;
            end else if ({1'b0, group_ff} >= active_groups_ff) begin
               remaining_in  = '0;
               res_status_in = STATUS_IGNORED;
            end else if (pile_ff) begin
               pileup_in    = bump(pileup_ff);
               rejected_in  = 1'b1;
               remaining_in = '0;
            end else begin
               if (group_ff == '0) accepted_in = bump(accepted_ff);
               cur_group_in = group_ff;
               remaining_in = mask_item_ff;
            end
         end
         FUNC_DATA_WORD: begin
            if (rejected_ff) begin
               res_status_in = STATUS_IGNORED;
            end else if (remaining_ff == '0) begin
               res_status_in = STATUS_NO_CHANNEL;
            end else begin
               remaining_in          = remaining_ff;
               remaining_in[low_bit] = 1'b0;
               if (!data_ch_ok) begin
                  res_status_in = STATUS_IGNORED;
               end else begin
                  res_used_in = data_ch;
                  chan_we_upd = 1'b1;
                  chan_wdata_upd[COUNT_WIDTH-1:0] = bump(hits_rd);
                  if (word_ff[OVF_BIT]) begin
                     chan_wdata_upd[CHAN_W-1:COUNT_WIDTH] = bump(ovf_rd);
                  end else begin
                     bin_we_upd = word_bin_ok;
                  end
               end
            end
         end
         FUNC_READ: begin
            case (sel_ff)
               SEL_TOTAL:    res_value_in = VALUE_W'(total_ff);
               SEL_PILEUP:   res_value_in = VALUE_W'(pileup_ff);
               SEL_ACCEPTED: res_value_in = VALUE_W'(accepted_ff);
               SEL_HITS: begin
                  if (rch_ok) res_value_in = VALUE_W'(hits_rd);
                  else res_status_in = STATUS_IGNORED;
               end
               SEL_OVERFLOW: begin
                  if (rch_ok) res_value_in = VALUE_W'(ovf_rd);
                  else res_status_in = STATUS_IGNORED;
               end
               SEL_BIN: begin
                  if (rch_ok && rbin_ok) res_value_in = VALUE_W'(bin_rdata);
                  else res_status_in = STATUS_IGNORED;
               end
               default: begin
                  res_status_in = STATUS_IGNORED;
               end
            endcase
         end
         FUNC_CLEAR: begin
            // the rams are zeroed by the sweep that follows
            rejected_in  = 1'b0;
            cur_group_in = '0;
            remaining_in = '0;
            total_in     = '0;
            pileup_in    = '0;
            accepted_in  = '0;
         end
         default: begin
            res_status_in = STATUS_IGNORED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_groups_ff <= ACTIVE_GROUPS_RESET;
         rejected_ff      <= 1'b0;
         cur_group_ff     <= '0;
         remaining_ff     <= '0;
         total_ff         <= '0;
         pileup_ff        <= '0;
         accepted_ff      <= '0;
         sweep_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid) active_groups_ff <= csr_active_groups;
         if (cmd.update) begin
            rejected_ff  <= rejected_in;
            cur_group_ff <= cur_group_in;
            remaining_ff <= remaining_in;
            total_ff     <= total_in;
            pileup_ff    <= pileup_in;
            accepted_ff  <= accepted_in;
         end
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         res_status_ff <= res_status_in;
         res_value_ff  <= res_value_in;
         res_used_ff   <= res_used_in;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
         rsp_used_ff   <= res_used_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign dp_status.sweep_last = sweep_last;
   assign dp_status.is_clear   = func_ff == FUNC_CLEAR;
   assign dp_status.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_read_value   = rsp_value_ff;
   assign rsp_channel_used = rsp_used_ff;

   phh_ram #(
      .WIDTH (CHAN_W),
      .DEPTH (CHANNELS)
   ) u_chan_ram (
      .clock   (clock),
      .wr_en   (chan_we),
      .wr_addr (chan_addr),
      .wr_data (chan_wdata),
      .rd_addr (chan_addr),
      .rd_data (chan_rdata)
   );

   phh_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (BIN_DEPTH)
   ) u_bin_ram (
      .clock   (clock),
      .wr_en   (bin_we),
      .wr_addr (bin_addr),
      .wr_data (bin_wdata),
      .rd_addr (bin_addr),
      .rd_data (bin_rdata)
   );

endmodule

### src/pulse_height_histogrammer_core.sv
// ----------------------------------------------------------------------------
// pulse_height_histogrammer_core
// Pulse height histogrammer for up to 64 channels in groups of 16.
// ----------------------------------------------------------------------------
// Items arrive on the req_ channel (valid/ready): event starts, group
// headers, data words, counter reads and clears. Every item gives exactly
// one result beat on the rsp_ channel (valid/ready) with a status, a read
// value and the channel a data word was counted on. csr_ takes the number
// of active groups and is always ready; write it only while idle.
// The result beat goes through counter ram lookup (registered read),
// read-modify-write update and hand-off to the output register. The
// sequencer takes a new item only in its idle step after the hand-off,
// so it finishes one item before it takes the next. A clear adds a
// sweep of CHANNELS*BINS = 1048576 entries that zeroes the rams one entry
// a cycle. After reset the same sweep runs before req_ready rises.
// The finished result sits in an output register, so the next item can be
// accepted while the receiver stalls; a stalled receiver holds the core
// in its hand-off step until the output register frees.
// ----------------------------------------------------------------------------
module pulse_height_histogrammer_core
   import phh_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [GROUP_W-1:0]  req_group_index,
   input  logic                req_pileup_flag,
   input  logic [MASK_W-1:0]   req_channel_mask,
   input  logic [WORD_W-1:0]   req_data_word,
   input  logic [SEL_W-1:0]    req_read_select,
   input  logic [RCH_W-1:0]    req_read_channel,
   input  logic [RBIN_W-1:0]   req_read_bin,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [VALUE_W-1:0]  rsp_read_value,
   output logic [RCH_W-1:0]    rsp_channel_used,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CFG_W-1:0]    csr_active_groups
);

   cmd_type       cmd;
   dp_status_type dp_status;

   assign csr_ready = 1'b1;

   phh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   phh_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .dp_status         (dp_status),
      .req_func          (req_func),
      .req_group_index   (req_group_index),
      .req_pileup_flag   (req_pileup_flag),
      .req_channel_mask  (req_channel_mask),
      .req_data_word     (req_data_word),
      .req_read_select   (req_read_select),
      .req_read_channel  (req_read_channel),
      .req_read_bin      (req_read_bin),
      .csr_valid         (csr_valid),
      .csr_active_groups (csr_active_groups),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_read_value    (rsp_read_value),
      .rsp_channel_used  (rsp_channel_used)
   );

endmodule
